/* design/hgc_pkg.sv */
// ----------------------------------------------------------------------------
// hgc_pkg
// Shared types, constants and geometry helpers for the group count engine.
// ----------------------------------------------------------------------------
package hgc_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int HALF_SLOTS  = TABLE_SLOTS / 2;
    localparam int SLOT_AW     = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = SLOT_AW + 1;
    localparam int LIM_W       = $clog2(HALF_SLOTS) + 1;
    localparam int CFG_W       = 10;
    localparam int KEY_W       = 64;
    localparam int ROWS_W      = 32;

    localparam logic [KEY_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [KEY_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam int               MIX_SH = 33;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_GROUP = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_OVF   = 2'd3;

    typedef struct packed {
        logic              used;
        logic [KEY_W-1:0]  key;
        logic [ROWS_W-1:0] rows;
    } hgc_entry_t;

    function automatic logic [LIM_W-1:0] active_limit(input logic [CFG_W-1:0] g);
        if (g == '0 || 32'(g) > 32'(HALF_SLOTS))
            return LIM_W'(HALF_SLOTS);
        else
            return LIM_W'(g);
    endfunction

    function automatic logic [SLOT_AW-1:0] slot_mask(input logic [LIM_W-1:0] lim);
        logic [SLOT_AW-1:0] x;
        x = SLOT_AW'({lim, 1'b0} - 1'b1);
        for (int i = 1; i < SLOT_AW; i++)
            x = x | (x >> i);
        return x;
    endfunction

endpackage

/* design/hgc_hash.sv */
// ----------------------------------------------------------------------------
// hgc_hash
// Iterative 64-bit key mixer: xor-shifts and two constant multiplies, each
// multiply built from three 32x32 partial products over successive cycles.
// ----------------------------------------------------------------------------
module hgc_hash
    import hgc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [KEY_W-1:0]    key,
    output logic                done,
    output logic [SLOT_AW-1:0]  hash
);

    logic              active_reg;
    logic              pass_reg;
    logic [1:0]        step_reg;
    logic              done_reg;
    logic [KEY_W-1:0]  v_reg;
    logic [KEY_W-1:0]  acc_reg;
    logic [KEY_W-1:0]  prod_reg;
    logic [KEY_W-1:0]  c;
    logic [31:0]       op_a;
    logic [31:0]       op_b;
    logic [KEY_W-1:0]  prod_next;
    logic [KEY_W-1:0]  sum;

    always_comb
    begin
        c = pass_reg ? MIX_C2 : MIX_C1;
        case (step_reg)
            2'd0:
            begin
                op_a = v_reg[31:0];
                op_b = c[31:0];
            end
            2'd1:
            begin
                op_a = v_reg[31:0];
                op_b = c[63:32];
            end
            default:
            begin
                op_a = v_reg[63:32];
                op_b = c[31:0];
            end
        endcase
        prod_next = {32'h0, op_a} * {32'h0, op_b};
        sum       = acc_reg + {prod_reg[31:0], 32'h0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pass_reg   <= 1'b0;
            step_reg   <= 2'd0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                pass_reg   <= 1'b0;
                step_reg   <= 2'd0;
            end
            else if (active_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    pass_reg <= 1'b1;
                    if (pass_reg)
                    begin
                        active_reg <= 1'b0;
                        done_reg   <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            v_reg <= key ^ (key >> MIX_SH);
        else if (active_reg)
        begin
            case (step_reg)
                2'd0:
                    prod_reg <= prod_next;
                2'd1:
                begin
                    acc_reg  <= prod_reg;
                    prod_reg <= prod_next;
                end
                2'd2:
                begin
                    acc_reg  <= sum;
                    prod_reg <= prod_next;
                end
                default:
                    v_reg <= sum ^ (sum >> MIX_SH);
            endcase
        end
    end

    assign done = done_reg;
    assign hash = v_reg[SLOT_AW-1:0];

endmodule

/* design/hash_group_count_engine_top.sv */
// ----------------------------------------------------------------------------
// hash_group_count_engine_top
// Groups 64-bit keys in a linear-probing table held in one synchronous memory
// and counts the rows per group; drains groups in slot order.
// ----------------------------------------------------------------------------
//   port group   | dir | handshake            | word
//   in           | in  | in_valid / in_stall  | op, key
//   out          | out | out_valid / out_stall| status, group_key, group_rows,
//                |     |                      | last_group
//   cfg          | in  | cfg_wr_en            | cfg_wr_data (group_limit)
//
// An add passes through the mixer, then probes the table memory (a read state
// and a check state per probe) and then loads the output register. A read
// scans slots (a read and a check state each) up to the next group and then
// on to the following one, and then loads the output register. One word is
// in flight at a time. After reset and after a clear, a sweep over all
// TABLE_SLOTS (1024) slots empties the memory; in_stall is high meanwhile. A
// finished result waits in the output register while the next word is accepted.
// ----------------------------------------------------------------------------
module hash_group_count_engine_top
    import hgc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          op,
    input  logic [KEY_W-1:0]    key,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [KEY_W-1:0]    group_key,
    output logic [ROWS_W-1:0]   group_rows,
    output logic                last_group,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_DRAIN_RD,
        S_DRAIN_CHK,
        S_LAST_RD,
        S_LAST_CHK,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [CFG_W-1:0]     limit_cfg_reg;
    logic [LIM_W-1:0]     groups_reg;
    logic                 overflow_reg;
    logic [CNT_W-1:0]     cursor_reg;
    logic [SLOT_AW-1:0]   sweep_reg;
    logic                 respond_reg;
    logic [SLOT_AW-1:0]   slot_reg;
    logic [CNT_W-1:0]     probe_reg;
    logic [CNT_W-1:0]     scan_reg;
    logic [KEY_W-1:0]     key_reg;
    logic                 res_add_reg;
    logic [1:0]           res_status_reg;
    logic [KEY_W-1:0]     res_key_reg;
    logic [ROWS_W-1:0]    res_rows_reg;
    logic                 res_last_reg;
    logic                 out_valid_reg;
    logic [1:0]           status_reg;
    logic [KEY_W-1:0]     group_key_reg;
    logic [ROWS_W-1:0]    group_rows_reg;
    logic                 last_group_reg;

    hgc_entry_t           mem [TABLE_SLOTS];
    hgc_entry_t           rd_data_reg;
    logic [SLOT_AW-1:0]   rd_addr;
    logic                 mem_we;
    logic [SLOT_AW-1:0]   mem_wa;
    hgc_entry_t           mem_wd;

    logic [LIM_W-1:0]     lim;
    logic [SLOT_AW-1:0]   mask;
    logic [CNT_W-1:0]     cap;
    logic                 accept;
    logic                 hash_start;
    logic                 hash_done;
    logic [SLOT_AW-1:0]   hash_slot;
    logic                 key_hit;
    logic                 room;
    logic [CNT_W-1:0]     scan_inc;
    logic                 out_free;
    logic                 out_load;

    hgc_hash u_hash
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key),
        .done  (hash_done),
        .hash  (hash_slot)
    );

    always_comb
    begin
        lim        = active_limit(limit_cfg_reg);
        mask       = slot_mask(lim);
        cap        = {1'b0, mask} + 1'b1;
        accept     = in_valid && (state_reg == S_IDLE);
        hash_start = accept && (op == OP_ADD);
        key_hit    = rd_data_reg.key == key_reg;
        room       = groups_reg < lim;
        scan_inc   = scan_reg + 1'b1;
        out_free   = !out_valid_reg || !out_stall;
        out_load   = (state_reg == S_DONE) && out_free;

        case (state_reg)
            S_DRAIN_RD, S_LAST_RD: rd_addr = scan_reg[SLOT_AW-1:0];
            default:               rd_addr = slot_reg;
        endcase

        mem_we = 1'b0;
        mem_wa = slot_reg;
        mem_wd = '{used: 1'b1, key: key_reg, rows: ROWS_W'(1)};
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = sweep_reg;
                mem_wd = '0;
            end
            S_PROBE_CHK:
            begin
                if (!rd_data_reg.used)
                    mem_we = room;
                else if (key_hit)
                begin
                    mem_we = 1'b1;
                    mem_wd.rows = (&rd_data_reg.rows) ? rd_data_reg.rows
                                                      : rd_data_reg.rows + 1'b1;
                end
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            limit_cfg_reg <= '0;
            groups_reg    <= '0;
            overflow_reg  <= 1'b0;
            cursor_reg    <= '0;
            sweep_reg     <= '0;
            respond_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                limit_cfg_reg <= cfg_wr_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == SLOT_AW'(TABLE_SLOTS - 1))
                    begin
                        groups_reg   <= '0;
                        overflow_reg <= 1'b0;
                        cursor_reg   <= '0;
                        state_reg    <= respond_reg ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        key_reg        <= key;
                        res_add_reg    <= 1'b0;
                        res_status_reg <= STAT_OK;
                        res_key_reg    <= '0;
                        res_rows_reg   <= '0;
                        res_last_reg   <= 1'b0;
                        case (op)
                            OP_ADD:
                            begin
                                res_add_reg <= 1'b1;
                                state_reg   <= S_HASH;
                            end
                            OP_READ:
                            begin
                                scan_reg <= cursor_reg;
                                if (overflow_reg)
                                begin
                                    res_status_reg <= STAT_OVF;
                                    state_reg      <= S_DONE;
                                end
                                else if (cursor_reg >= cap)
                                begin
                                    res_status_reg <= STAT_EMPTY;
                                    state_reg      <= S_DONE;
                                end
                                else
                                    state_reg <= S_DRAIN_RD;
                            end
                            OP_CLEAR:
                            begin
                                sweep_reg   <= '0;
                                respond_reg <= 1'b1;
                                state_reg   <= S_CLEAR;
                            end
                            default:
                                state_reg <= S_DONE;
                        endcase
                    end
                end
                S_HASH:
                begin
                    if (hash_done)
                    begin
                        slot_reg  <= hash_slot & mask;
                        probe_reg <= '0;
                        state_reg <= S_PROBE_RD;
                    end
                end
                S_PROBE_RD:
                    state_reg <= S_PROBE_CHK;
                S_PROBE_CHK:
                begin
                    if (!rd_data_reg.used)
                    begin
                        if (room)
                            groups_reg <= groups_reg + 1'b1;
                        else
                            overflow_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (key_hit)
                        state_reg <= S_DONE;
                    else if (probe_reg + 1'b1 == cap)
                    begin
                        overflow_reg <= 1'b1;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        slot_reg  <= (slot_reg + 1'b1) & mask;
                        probe_reg <= probe_reg + 1'b1;
                        state_reg <= S_PROBE_RD;
                    end
                end
                S_DRAIN_RD:
                    state_reg <= S_DRAIN_CHK;
                S_DRAIN_CHK:
                begin
                    scan_reg <= scan_inc;
                    if (rd_data_reg.used)
                    begin
                        res_status_reg <= STAT_GROUP;
                        res_key_reg    <= rd_data_reg.key;
                        res_rows_reg   <= rd_data_reg.rows;
                        cursor_reg     <= scan_inc;
                        if (scan_inc >= cap)
                        begin
                            res_last_reg <= 1'b1;
                            state_reg    <= S_DONE;
                        end
                        else
                            state_reg <= S_LAST_RD;
                    end
                    else if (scan_inc >= cap)
                    begin
                        res_status_reg <= STAT_EMPTY;
                        state_reg      <= S_DONE;
                    end
                    else
                        state_reg <= S_DRAIN_RD;
                end
                S_LAST_RD:
                    state_reg <= S_LAST_CHK;
                S_LAST_CHK:
                begin
                    scan_reg <= scan_inc;
                    if (rd_data_reg.used)
                        state_reg <= S_DONE;
                    else if (scan_inc >= cap)
                    begin
                        res_last_reg <= 1'b1;
                        state_reg    <= S_DONE;
                    end
                    else
                        state_reg <= S_LAST_RD;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        status_reg      <= res_add_reg ? (overflow_reg ? STAT_OVF : STAT_OK)
                                                       : res_status_reg;
                        group_key_reg   <= res_key_reg;
                        group_rows_reg  <= res_rows_reg;
                        last_group_reg  <= res_last_reg;
                        respond_reg     <= 1'b0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall    = state_reg != S_IDLE;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign group_key   = group_key_reg;
    assign group_rows  = group_rows_reg;
    assign last_group  = last_group_reg;

endmodule

/* tb/tb_hash_group_count_engine_top.sv */
// ----------------------------------------------------------------------------
// tb_hash_group_count_engine_top
// Self-checking bench for the hashed group counter: directed and random add,
// read, clear and unused-op words over many group limits. A scoreboard keeps
// its own copy of the probing table and checks every result word in order.
// ----------------------------------------------------------------------------
module tb_hash_group_count_engine_top
    import hgc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int         WATCHDOG = 40000;

    typedef struct {
        logic [1:0]        status;
        logic [KEY_W-1:0]  gkey;
        logic [ROWS_W-1:0] gcount;
        logic              last;
    } group_word_t;

    class group_scoreboard;
        bit                used [TABLE_SLOTS];
        logic [KEY_W-1:0]  skey [TABLE_SLOTS];
        logic [ROWS_W-1:0] srows[TABLE_SLOTS];
        int unsigned       groups;
        int unsigned       cursor;
        bit                ovf;
        logic [CFG_W-1:0]  limit;
        group_word_t       expected_q[$];
        int                errors;
        int                n_adds, n_reads, n_groups_out, n_ovf;

        function new();
            limit = '0;
            wipe();
        endfunction

        function void wipe();
            foreach (used[i]) used[i] = 1'b0;
            groups = 0;
            cursor = 0;
            ovf    = 1'b0;
        endfunction

        function logic [63:0] mix(logic [63:0] v);
            v = v ^ (v >> MIX_SH);
            v = v * 64'hff51afd7ed558ccd;
            v = v ^ (v >> MIX_SH);
            v = v * 64'hc4ceb9fe1a85ec53;
            v = v ^ (v >> MIX_SH);
            return v;
        endfunction

        function int unsigned eff_limit();
            int unsigned g;
            g = 32'(limit);
            if (g == 0 || g > TABLE_SLOTS / 2)
                g = TABLE_SLOTS / 2;
            return g;
        endfunction

        function int unsigned table_size(int unsigned lim);
            int unsigned sz;
            sz = 2;
            while (sz < 2 * lim && sz <= TABLE_SLOTS / 2)
                sz = sz * 2;
            return sz;
        endfunction

        function void add_key(logic [KEY_W-1:0] k);
            int unsigned lim, sz, slot;
            bit done;
            lim  = eff_limit();
            sz   = table_size(lim);
            slot = 32'(mix(k)) & (sz - 1);
            done = 1'b0;
            for (int unsigned p = 0; p < sz && !done; p++)
            begin
                if (!used[slot])
                begin
                    if (groups >= lim)
                        ovf = 1'b1;
                    else
                    begin
                        used[slot]  = 1'b1;
                        skey[slot]  = k;
                        srows[slot] = 1;
                        groups++;
                    end
                    done = 1'b1;
                end
                else if (skey[slot] == k)
                begin
                    if (srows[slot] != 32'hFFFF_FFFF)
                        srows[slot]++;
                    done = 1'b1;
                end
                else
                    slot = (slot + 1) & (sz - 1);
            end
            if (!done)
                ovf = 1'b1;
        endfunction

        function void note_word(logic [1:0] op, logic [KEY_W-1:0] k);
            group_word_t w;
            int unsigned sz, s, t;
            w = '{STAT_OK, '0, '0, 1'b0};
            if (op == OP_ADD)
            begin
                n_adds++;
                add_key(k);
                w.status = ovf ? STAT_OVF : STAT_OK;
            end
            else if (op == OP_READ)
            begin
                n_reads++;
                if (ovf)
                    w.status = STAT_OVF;
                else
                begin
                    sz = table_size(eff_limit());
                    s  = cursor;
                    while (s < sz && !used[s])
                        s++;
                    if (s >= sz)
                        w.status = STAT_EMPTY;
                    else
                    begin
                        w.status = STAT_GROUP;
                        w.gkey   = skey[s];
                        w.gcount = srows[s];
                        t = s + 1;
                        while (t < sz && !used[t])
                            t++;
                        w.last = (t >= sz);
                        cursor = s + 1;
                    end
                end
            end
            else if (op == OP_CLEAR)
                wipe();
            if (w.status == STAT_GROUP)
                n_groups_out++;
            if (w.status == STAT_OVF)
                n_ovf++;
            expected_q.push_back(w);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_word(logic [1:0] st, logic [KEY_W-1:0] gk, logic [ROWS_W-1:0] gc,
                        logic lg);
            group_word_t e;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result status %0d", st));
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.status)
                report($sformatf("status %0d, want %0d", st, e.status));
            if (gk !== e.gkey)
                report($sformatf("group_key %h, want %h", gk, e.gkey));
            if (gc !== e.gcount)
                report($sformatf("group_rows %0d, want %0d", gc, e.gcount));
            if (lg !== e.last)
                report($sformatf("last_group %0b, want %0b", lg, e.last));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         op;
    logic [KEY_W-1:0]   key;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic [KEY_W-1:0]   group_key;
    logic [ROWS_W-1:0]  group_rows;
    logic               last_group;
    logic               cfg_wr_en;
    logic [CFG_W-1:0]   cfg_wr_data;

    group_scoreboard sb = new();

    int  burst_left;
    bit  gapless;
    bit  hold_req;
    int  hold_left;
    int  stall_mode;
    int  mode_left;
    int  idle_cycles;
    int  n_phases;
    logic [KEY_W-1:0] pool[$];

    hash_group_count_engine_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .key         (key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .group_key   (group_key),
        .group_rows  (group_rows),
        .last_group  (last_group),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(status, group_key, group_rows, last_group);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog expired with %0d results pending", sb.expected_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 400;
            hold_req  = 1'b0;
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(16, 96);
        end
        mode_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall = 1'b1;
        end
        else if (stall_mode == 0)
            out_stall = 1'b0;
        else if (stall_mode == 1)
            out_stall = ($urandom_range(0, 3) == 0);
        else
            out_stall = ($urandom_range(0, 9) < 7);
    end

    task send_word(logic [1:0] o, logic [KEY_W-1:0] k);
        in_valid = 1'b1;
        op       = o;
        key      = k;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(o, k);
        @(negedge clk);
        if (!gapless)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                in_valid = 1'b0;
                op       = 2'($urandom);
                key      = {$urandom, $urandom};
                repeat ($urandom_range(1, 8))
                    @(negedge clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task drain_results();
        in_valid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (40)
            @(negedge clk);
    endtask

    task write_limit(logic [CFG_W-1:0] v);
        drain_results();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        sb.limit    = v;
        n_phases++;
    endtask

    function logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 9))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return '0;
            3: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task random_phase(logic [CFG_W-1:0] lim, int words, int pool_size);
        logic [KEY_W-1:0] k;
        int r;
        write_limit(lim);
        gapless = ($urandom_range(0, 3) == 0);
        send_word(OP_CLEAR, rand_key());
        pool.delete();
        for (int i = 0; i < pool_size; i++)
            pool.push_back(rand_key());
        for (int i = 0; i < words; i++)
        begin
            r = $urandom_range(0, 99);
            k = pool[$urandom_range(0, pool.size() - 1)];
            if (r < 75)
                send_word(OP_ADD, k);
            else if (r < 93)
                send_word(OP_READ, rand_key());
            else if (r < 96)
                send_word(OP_SPARE, rand_key());
            else if (r < 98)
                send_word(OP_ADD, {$urandom, $urandom});
            else
                send_word(OP_CLEAR, k);
        end
        for (int i = 0; i < pool_size + 2 && i < 20; i++)
            send_word(OP_READ, rand_key());
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_ADD;
        key         = '0;
        out_stall   = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        hold_req    = 1'b0;
        hold_left   = 0;
        mode_left   = 0;
        stall_mode  = 0;
        idle_cycles = 0;
        burst_left  = 4;
        gapless     = 1'b0;
        n_phases    = 0;
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;

        // directed: full-size table, extreme keys, repeats, drain with late adds
        hold_req = 1'b1;
        send_word(OP_ADD, 64'h8000_0000_0000_0000);
        send_word(OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF);
        send_word(OP_ADD, '0);
        send_word(OP_ADD, '1);
        send_word(OP_ADD, '1);
        send_word(OP_ADD, 64'h8000_0000_0000_0000);
        send_word(OP_SPARE, '1);
        send_word(OP_READ, '0);
        send_word(OP_READ, '0);
        send_word(OP_ADD, 64'h0123_4567_89AB_CDEF);
        send_word(OP_READ, '0);
        send_word(OP_READ, '0);
        send_word(OP_READ, '0);
        send_word(OP_READ, '0);
        send_word(OP_READ, '0);
        send_word(OP_CLEAR, '0);
        send_word(OP_READ, '0);

        // directed: smallest table, overflow is sticky until clear
        write_limit(10'd1);
        send_word(OP_ADD, 64'd5);
        send_word(OP_ADD, 64'd5);
        send_word(OP_ADD, 64'd6);
        send_word(OP_ADD, 64'd5);
        send_word(OP_READ, '0);
        send_word(OP_CLEAR, '0);
        send_word(OP_ADD, 64'd6);
        send_word(OP_READ, '0);

        // random: limits sweep extremes, odd sizes, saturating values
        random_phase(10'd2, 40, 4);
        random_phase(10'd1023, 40, 30);
        random_phase(10'd3, 40, 6);
        random_phase(10'd0, 60, 60);
        random_phase(10'd5, 40, 5);
        random_phase(10'd16, 50, 24);
        random_phase(10'd512, 40, 40);
        random_phase(10'd513, 40, 20);
        random_phase(10'd64, 60, 50);
        random_phase(10'd682, 40, 20);
        random_phase(10'd341, 40, 20);
        random_phase(10'd1, 30, 3);
        random_phase(10'd8, 40, 8);
        random_phase(10'd128, 40, 30);
        random_phase(10'($urandom_range(1, 1023)), 40, 25);

        drain_results();
        $display("covered %0d phases: %0d adds, %0d reads, %0d groups drained",
                 n_phases, sb.n_adds, sb.n_reads, sb.n_groups_out);
        $display("overflow answers %0d, mismatches %0d", sb.n_ovf, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
